/* rtl/assert_macros.svh */
// assertion macros used by the allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* rtl/bpfa_pkg.sv */
// shared types and constants of the bitmap page frame allocator
`timescale 1ns / 1ps

package bpfa_pkg;

    localparam int NUM_PAGES_DEF      = 65536;
    localparam int SCAN_WORD_BITS_DEF = 64;
    localparam int INDEX_SPAN         = 65536;

    localparam int CNT_W  = 17;
    localparam int PAGE_W = 16;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [OP_W-1:0] OP_REQUEST   = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
    localparam logic [OP_W-1:0] OP_LOCK      = 3'd2;
    localparam logic [OP_W-1:0] OP_RESERVE   = 3'd3;
    localparam logic [OP_W-1:0] OP_UNRESERVE = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALREADY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd3;

    typedef struct packed {
        logic found;
        logic at_end;
    } t_scan_info;

endpackage

/* rtl/bpfa_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bpfa_scan.sv */
// first-free search over one map word, masked by hint and page limit
`timescale 1ns / 1ps

module bpfa_scan import bpfa_pkg::*; #(
    parameter int WORD_BITS = SCAN_WORD_BITS_DEF,
    parameter int ADDR_W = 10,
    localparam int OFF_W = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [ADDR_W-1:0]    i_addr,
    input  logic                 i_first,
    input  logic [OFF_W-1:0]     i_hint_off,
    input  logic [CNT_W-1:0]     i_limit,
    output logic [WORD_BITS-1:0] o_pick,
    output t_scan_info           o_info
);

    logic [CNT_W:0]         base;
    logic [CNT_W:0]         lim_x;
    logic [CNT_W:0]         rem;
    logic [CNT_W:0]         end_pg;
    logic [OFF_W:0]         span;
    logic [WORD_BITS-1:0]   vmask;
    logic [WORD_BITS-1:0]   avail;

    assign base   = (CNT_W + 1)'({i_addr, {OFF_W{1'b0}}});
    assign lim_x  = {1'b0, i_limit};
    assign rem    = lim_x - base;
    assign end_pg = base + (CNT_W + 1)'(WORD_BITS);

    always_comb begin
        if (lim_x <= base) begin
            span = '0;
        end else if (rem >= (CNT_W + 1)'(WORD_BITS)) begin
            span = (OFF_W + 1)'(WORD_BITS);
        end else begin
            span = rem[OFF_W:0];
        end
    end

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            vmask[i] = ((OFF_W + 1)'(i) < span) && (!i_first || (OFF_W'(i) >= i_hint_off));
        end
    end

    assign avail  = ~i_word & vmask;
    // isolate lowest free bit
    assign o_pick = avail & (~avail + WORD_BITS'(1));

    assign o_info.found  = |avail;
    assign o_info.at_end = (end_pg >= lim_x);

endmodule

/* rtl/bitmap_page_frame_allocator_core.sv */
// top level of the bitmap page frame allocator
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------------
//  in       | i_in_valid / o_in_stall      | i_operation, i_page_index
//  out      | o_out_valid / i_out_stall    | o_status, o_granted_page, o_free_count,
//           |                              | o_used_count, o_reserved_count
//  cfg      | i_cfg_valid / o_cfg_ready    | i_total_pages
//
// free, lock, reserve and unreserve read one map word, then modify and write it back if the page changes
// a request scans map words from the hint word on, one word a cycle, until a free page or the page limit
// after reset the map is cleared one word a cycle, o_in_stall high meanwhile;
// cfg writes are taken at any time
// a new request is taken while a result waits; the next result waits for the output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bitmap_page_frame_allocator_core import bpfa_pkg::*; #(
    parameter int NUM_PAGES      = NUM_PAGES_DEF,
    parameter int SCAN_WORD_BITS = SCAN_WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [PAGE_W-1:0] i_page_index,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [PAGE_W-1:0] o_granted_page,
    output logic [CNT_W-1:0]  o_free_count,
    output logic [CNT_W-1:0]  o_used_count,
    output logic [CNT_W-1:0]  o_reserved_count,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_total_pages
);

    localparam int LIM_CAP = (NUM_PAGES < INDEX_SPAN) ? NUM_PAGES : INDEX_SPAN;
    localparam int W       = SCAN_WORD_BITS;
    localparam int OFF_W   = $clog2(W);
    localparam int DEPTH   = (LIM_CAP + W - 1) / W;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CNT_W-1:0]  LIM_CAP_V = CNT_W'(LIM_CAP);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    function automatic logic [CNT_W-1:0] lim_of(input logic [CNT_W-1:0] t);
        return (t > LIM_CAP_V) ? LIM_CAP_V : t;
    endfunction

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
        return (v == '0) ? '0 : v - CNT_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] word_of(input logic [CNT_W-1:0] p);
        return ADDR_W'(p >> OFF_W);
    endfunction

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [OP_W-1:0]     r_op, n_op;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_first, n_first;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [CNT_W-1:0]    r_hint, n_hint;
    logic [CNT_W-1:0]    r_free, n_free;
    logic [CNT_W-1:0]    r_used, n_used;
    logic [CNT_W-1:0]    r_resv, n_resv;
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [PAGE_W-1:0]   r_granted, n_granted;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [W-1:0]        ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [W-1:0]        ram_rdata;

    logic [W-1:0]        pick;
    t_scan_info          scan;
    logic [OFF_W-1:0]    pick_off;
    logic [CNT_W-1:0]    lim;
    logic                in_acc;
    logic                out_free;
    logic                done;
    logic [OFF_W-1:0]    page_off;
    logic [W-1:0]        page_bit;
    logic                page_set;
    logic                page_oor;
    logic [CNT_W-1:0]    pick_page;

    bpfa_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bpfa_scan #(
        .WORD_BITS (W),
        .ADDR_W    (ADDR_W)
    ) u_scan (
        .i_word     (ram_rdata),
        .i_addr     (r_addr),
        .i_first    (r_first),
        .i_hint_off (r_hint[OFF_W-1:0]),
        .i_limit    (lim),
        .o_pick     (pick),
        .o_info     (scan)
    );

    always_comb begin
        pick_off = '0;
        for (int i = 0; i < W; i++) begin
            if (pick[i]) begin
                pick_off = pick_off | OFF_W'(i);
            end
        end
    end

    assign lim       = lim_of(r_total);
    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pick_page = CNT_W'({r_addr, pick_off});
    assign page_off  = r_page[OFF_W-1:0];
    assign page_bit  = W'(1) << page_off;
    assign page_set  = ram_rdata[page_off];
    assign page_oor  = ({1'b0, r_page} >= lim);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_op        = r_op;
        n_page      = r_page;
        n_addr      = r_addr;
        n_first     = r_first;
        n_total     = r_total;
        n_hint      = r_hint;
        n_free      = r_free;
        n_used      = r_used;
        n_resv      = r_resv;
        n_status    = r_status;
        n_granted   = r_granted;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_addr;
        done        = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op      = i_operation;
                    n_page    = i_page_index;
                    n_first   = 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = (i_operation == OP_REQUEST) ? word_of(r_hint)
                                                            : word_of({1'b0, i_page_index});
                    n_addr    = ram_raddr;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_op == OP_REQUEST) begin
                    if (r_hint >= lim) begin
                        if (out_free) begin
                            done      = 1'b1;
                            n_status  = ST_NOFREE;
                            n_granted = '0;
                        end
                    end else if (scan.found) begin
                        if (out_free) begin
                            done      = 1'b1;
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | pick;
                            n_hint    = pick_page;
                            n_free    = dec_sat(r_free);
                            n_used    = inc_sat(r_used);
                            n_status  = ST_DONE;
                            n_granted = pick_page[PAGE_W-1:0];
                        end
                    end else if (scan.at_end) begin
                        if (out_free) begin
                            done      = 1'b1;
                            n_hint    = lim;
                            n_status  = ST_NOFREE;
                            n_granted = '0;
                        end
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_addr + ADDR_W'(1);
                        n_addr    = ram_raddr;
                        n_first   = 1'b0;
                    end
                end else if (out_free) begin
                    done      = 1'b1;
                    n_granted = '0;
                    n_status  = ST_DONE;
                    case (r_op) inside
                        OP_LOCK, OP_RESERVE: begin
                            if (page_oor) begin
                                n_status = ST_RANGE;
                            end else if (page_set) begin
                                n_status = ST_ALREADY;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = ram_rdata | page_bit;
                                n_free    = dec_sat(r_free);
                                if (r_op == OP_LOCK) begin
                                    n_used = inc_sat(r_used);
                                end else begin
                                    n_resv = inc_sat(r_resv);
                                end
                            end
                        end
                        OP_FREE, OP_UNRESERVE: begin
                            if (page_oor) begin
                                n_status = ST_RANGE;
                            end else if (!page_set) begin
                                n_status = ST_ALREADY;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = ram_rdata & ~page_bit;
                                n_free    = inc_sat(r_free);
                                if (r_op == OP_FREE) begin
                                    n_used = dec_sat(r_used);
                                end else begin
                                    n_resv = dec_sat(r_resv);
                                end
                                if (r_hint > {1'b0, r_page}) begin
                                    n_hint = {1'b0, r_page};
                                end
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                        end
                    endcase
                end
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            n_total = i_total_pages;
            n_free  = lim_of(i_total_pages);
        end

        n_out_valid = done || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= CNT_W'(INDEX_SPAN);
            r_hint      <= '0;
            r_free      <= CNT_W'(INDEX_SPAN);
            r_used      <= '0;
            r_resv      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_total     <= n_total;
            r_hint      <= n_hint;
            r_free      <= n_free;
            r_used      <= n_used;
            r_resv      <= n_resv;
            r_out_valid <= n_out_valid;
        end
        r_op      <= n_op;
        r_page    <= n_page;
        r_addr    <= n_addr;
        r_first   <= n_first;
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_granted_page   = r_granted;
    assign o_free_count     = r_free;
    assign o_used_count     = r_used;
    assign o_reserved_count = r_resv;
    assign o_cfg_ready      = 1'b1;

    `ASSERT_NEVER(a_rw_same_word, i_clk, i_rst_n, ram_we && ram_re && (ram_waddr == ram_raddr))
    `ASSERT_NEVER(a_no_result_overwrite, i_clk, i_rst_n, done && r_out_valid && i_out_stall)
    `ASSERT_NEVER(a_no_read_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR) && ram_re)
    `ASSERT_NEVER(a_grant_done, i_clk, i_rst_n, r_out_valid && |r_granted && (r_status != ST_DONE))

endmodule

/* bench/bpfa_checker.sv */
// scoreboard for the page frame allocator: tracks the page map, predicts each reply and compares
`timescale 1ns / 1ps

module bpfa_checker import bpfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [PAGE_W-1:0] i_page_index,

    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [STAT_W-1:0] i_status,
    input  logic [PAGE_W-1:0] i_granted_page,
    input  logic [CNT_W-1:0]  i_free_count,
    input  logic [CNT_W-1:0]  i_used_count,
    input  logic [CNT_W-1:0]  i_reserved_count,

    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CNT_W-1:0]  i_total_pages,

    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PAGE_W-1:0] granted;
        logic [CNT_W-1:0]  free_cnt;
        logic [CNT_W-1:0]  used_cnt;
        logic [CNT_W-1:0]  rsvd_cnt;
    } t_alloc_reply;

    bit               page_taken [INDEX_SPAN];
    logic [CNT_W-1:0] scan_hint;
    logic [CNT_W-1:0] free_pages_m;
    logic [CNT_W-1:0] used_pages_m;
    logic [CNT_W-1:0] rsvd_pages_m;
    logic [CNT_W-1:0] total_pages_m;
    t_alloc_reply     replies_due [$];
    int               fail_cnt = 0;

    function automatic logic [CNT_W-1:0] page_limit(input logic [CNT_W-1:0] tot);
        logic [CNT_W-1:0] lim;
        lim = tot;
        if (lim > NUM_PAGES_DEF) lim = CNT_W'(NUM_PAGES_DEF);
        if (lim > INDEX_SPAN) lim = CNT_W'(INDEX_SPAN);
        return lim;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

    function automatic t_alloc_reply apply_request(input logic [OP_W-1:0] op,
                                                   input logic [PAGE_W-1:0] pg);
        t_alloc_reply     r;
        logic [CNT_W-1:0] lim;
        int               p;
        r        = '0;
        r.status = ST_DONE;
        lim      = page_limit(total_pages_m);
        if (op == OP_REQUEST) begin
            p = int'(scan_hint);
            while (p < int'(lim) && page_taken[p]) p++;
            if (p < int'(lim)) begin
                page_taken[p] = 1'b1;
                scan_hint     = CNT_W'(p);
                free_pages_m  = sat_dec(free_pages_m);
                used_pages_m  = sat_inc(used_pages_m);
                r.granted     = PAGE_W'(p);
            end else begin
                if (scan_hint < lim) scan_hint = lim;
                r.status = ST_NOFREE;
            end
        end else if (op > OP_UNRESERVE || {1'b0, pg} >= lim) begin
            r.status = ST_RANGE;
        end else if (op == OP_LOCK || op == OP_RESERVE) begin
            if (page_taken[pg]) begin
                r.status = ST_ALREADY;
            end else begin
                page_taken[pg] = 1'b1;
                free_pages_m   = sat_dec(free_pages_m);
                if (op == OP_LOCK) used_pages_m = sat_inc(used_pages_m);
                else rsvd_pages_m = sat_inc(rsvd_pages_m);
            end
        end else begin
            if (!page_taken[pg]) begin
                r.status = ST_ALREADY;
            end else begin
                page_taken[pg] = 1'b0;
                free_pages_m   = sat_inc(free_pages_m);
                if (op == OP_FREE) used_pages_m = sat_dec(used_pages_m);
                else rsvd_pages_m = sat_dec(rsvd_pages_m);
                if (scan_hint > {1'b0, pg}) scan_hint = {1'b0, pg};
            end
        end
        r.free_cnt = free_pages_m;
        r.used_cnt = used_pages_m;
        r.rsvd_cnt = rsvd_pages_m;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [CNT_W-1:0] want_v,
                                 input logic [CNT_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_alloc_reply want;
        if (!i_rst_n) begin
            page_taken    = '{default: 1'b0};
            scan_hint     = '0;
            total_pages_m = CNT_W'(INDEX_SPAN);
            free_pages_m  = CNT_W'(INDEX_SPAN);
            used_pages_m  = '0;
            rsvd_pages_m  = '0;
            replies_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                total_pages_m = i_total_pages;
                free_pages_m  = page_limit(i_total_pages);
            end
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $error("reply with no request pending");
                    fail_cnt++;
                end else begin
                    want = replies_due.pop_front();
                    compare_field("status", CNT_W'(want.status), CNT_W'(i_status));
                    compare_field("granted_page", CNT_W'(want.granted),
                                  CNT_W'(i_granted_page));
                    compare_field("free_count", want.free_cnt, i_free_count);
                    compare_field("used_count", want.used_cnt, i_used_count);
                    compare_field("reserved_count", want.rsvd_cnt, i_reserved_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                replies_due.push_back(apply_request(i_operation, i_page_index));
            end
        end
        o_pending    <= replies_due.size();
        o_fail_count <= fail_cnt;
    end

endmodule

/* bench/tb_bitmap_page_frame_allocator_core.sv */
// testbench top for the page frame allocator: stimulus, flow control, watchdog and verdict
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator_core import bpfa_pkg::*;;

    localparam logic [OP_W-1:0] OP_BAD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_BAD_LAST  = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 160;

    typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_operation;
    logic [PAGE_W-1:0] i_page_index;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [STAT_W-1:0] o_status;
    logic [PAGE_W-1:0] o_granted_page;
    logic [CNT_W-1:0]  o_free_count;
    logic [CNT_W-1:0]  o_used_count;
    logic [CNT_W-1:0]  o_reserved_count;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_total_pages;

    int       fail_count;
    int       replies_pending;
    int       burst_left = 0;
    int       cur_limit  = INDEX_SPAN;
    int       idle_cycles;
    logic     long_hold_go;
    logic     hold_done;
    int       hold_left;
    int       mode_left;
    t_rx_mode rx_mode;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    bitmap_page_frame_allocator_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_page_index     (i_page_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_granted_page   (o_granted_page),
        .o_free_count     (o_free_count),
        .o_used_count     (o_used_count),
        .o_reserved_count (o_reserved_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_total_pages    (i_total_pages)
    );

    bpfa_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_page_index     (i_page_index),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_granted_page   (o_granted_page),
        .i_free_count     (o_free_count),
        .i_used_count     (o_used_count),
        .i_reserved_count (o_reserved_count),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_total_pages    (i_total_pages),
        .o_fail_count     (fail_count),
        .o_pending        (replies_pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_mode     <= RX_FLOW;
            mode_left   <= 64;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (long_hold_go && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 128);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FLOW:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 6);
                default:  i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                     || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_op(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_page_index <= pg;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (replies_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_total_pages(input logic [CNT_W-1:0] v);
        wait_drained();
        i_cfg_valid   <= 1'b1;
        i_total_pages <= v;
        cur_limit = (v > INDEX_SPAN) ? INDEX_SPAN : int'(v);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [PAGE_W-1:0] pick_page(input int lim);
        int roll;
        int span;
        roll = $urandom_range(0, 99);
        span = (lim < 1) ? 1 : ((lim > 160) ? 160 : lim);
        if (roll < 70) return PAGE_W'($urandom_range(0, span - 1));
        if (roll < 80 && lim > 0) return PAGE_W'(lim - 1 - $urandom_range(0, span - 1));
        if (roll < 88) return PAGE_W'(lim + $urandom_range(0, 2) - 1);
        return PAGE_W'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return OP_REQUEST;
        if (roll < 52) return OP_FREE;
        if (roll < 65) return OP_LOCK;
        if (roll < 77) return OP_RESERVE;
        if (roll < 94) return OP_UNRESERVE;
        return OP_BAD_FIRST + OP_W'($urandom_range(0, 2));
    endfunction

    initial begin : stimulus
        int limits [10];
        limits = '{65536, 1, 64, 100, 7, 4096, 65536, 0, 300, 65535};
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_operation   <= OP_REQUEST;
        i_page_index  <= '0;
        i_cfg_valid   <= 1'b0;
        i_total_pages <= '0;
        long_hold_go  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_total_pages(17'd65536);
        send_op(OP_FREE, 16'd0);
        send_op(OP_REQUEST, 16'd0);
        send_op(OP_REQUEST, 16'hFFFF);
        send_op(OP_LOCK, 16'hFFFF);
        send_op(OP_LOCK, 16'hFFFF);
        send_op(OP_RESERVE, 16'd100);
        send_op(OP_RESERVE, 16'd100);
        send_op(OP_UNRESERVE, 16'd100);
        send_op(OP_UNRESERVE, 16'd100);
        send_op(OP_FREE, 16'd0);
        send_op(OP_REQUEST, 16'd0);
        send_op(OP_BAD_FIRST, 16'd0);
        send_op(OP_BAD_LAST, 16'hFFFF);
        send_op(OP_UNRESERVE, 16'hFFFF);
        send_op(OP_RESERVE, 16'd1);
        send_op(OP_RESERVE, 16'd200);
        send_op(OP_FREE, 16'd200);

        // small limit: grant pages, free one out of range, then free one to pull the hint back
        set_total_pages(17'd4);
        send_op(OP_REQUEST, 16'd0);
        send_op(OP_REQUEST, 16'd0);
        send_op(OP_REQUEST, 16'd0);
        send_op(OP_FREE, 16'd5);
        send_op(OP_FREE, 16'd1);
        send_op(OP_REQUEST, 16'd0);

        set_total_pages(17'd0);
        send_op(OP_REQUEST, 16'd0);
        send_op(OP_LOCK, 16'd0);

        for (int ph = 0; ph < 10; ph++) begin
            set_total_pages(CNT_W'(limits[ph]));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == 60) long_hold_go <= 1'b1;
                if (ph == 5 && k == 80) wait_drained();
                send_op(pick_op(), pick_page(cur_limit));
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* bitmap_page_frame_allocator_core.f */
+incdir+rtl
rtl/bpfa_pkg.sv
rtl/bpfa_ram.sv
rtl/bpfa_scan.sv
rtl/bitmap_page_frame_allocator_core.sv
bench/bpfa_checker.sv
bench/tb_bitmap_page_frame_allocator_core.sv
